[rtl/core/mpce_pkg.sv]
// shared types, codes and the period table for the pattern cell encoder
`default_nettype none

package mpce_pkg;

    localparam int unsigned PERIOD_W = 12;

    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 12'd113;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 12'd856;

    // input effect kinds
    typedef enum logic [4:0] {
        KIND_NONE       = 5'd0,
        KIND_ARPEGGIO   = 5'd1,
        KIND_PORTA_UP   = 5'd2,
        KIND_PORTA_DOWN = 5'd3,
        KIND_TONEPORTA  = 5'd4,
        KIND_VIBRATO    = 5'd5,
        KIND_TONEP_VOL  = 5'd6,
        KIND_VIBRA_VOL  = 5'd7,
        KIND_TREMOLO    = 5'd8,
        KIND_PANNING    = 5'd9,
        KIND_OFFSET     = 5'd10,
        KIND_VOLSLIDE   = 5'd11,
        KIND_JUMP       = 5'd12,
        KIND_VOLUME     = 5'd13,
        KIND_BREAK      = 5'd14,
        KIND_SPEED      = 5'd15,
        KIND_TEMPO      = 5'd16,
        KIND_SPECIAL    = 5'd17,
        KIND_RETRIG     = 5'd18
    } effect_kind_t;

    // volume column kinds
    typedef enum logic [1:0] {
        VOL_NONE  = 2'd0,
        VOL_SET   = 2'd1,
        VOL_OTHER = 2'd2
    } vol_kind_t;

    // output command nibbles
    localparam logic [3:0] CMD_NONE      = 4'h0;
    localparam logic [3:0] CMD_PORTA_UP  = 4'h1;
    localparam logic [3:0] CMD_PORTA_DN  = 4'h2;
    localparam logic [3:0] CMD_TONEPORTA = 4'h3;
    localparam logic [3:0] CMD_VIBRATO   = 4'h4;
    localparam logic [3:0] CMD_TONEP_VOL = 4'h5;
    localparam logic [3:0] CMD_VIBRA_VOL = 4'h6;
    localparam logic [3:0] CMD_TREMOLO   = 4'h7;
    localparam logic [3:0] CMD_PANNING   = 4'h8;
    localparam logic [3:0] CMD_OFFSET    = 4'h9;
    localparam logic [3:0] CMD_VOLSLIDE  = 4'hA;
    localparam logic [3:0] CMD_JUMP      = 4'hB;
    localparam logic [3:0] CMD_VOLUME    = 4'hC;
    localparam logic [3:0] CMD_BREAK     = 4'hD;
    localparam logic [3:0] CMD_EXTENDED  = 4'hE;
    localparam logic [3:0] CMD_SPEED     = 4'hF;

    // extended sub-command nibbles
    localparam logic [3:0] EXT_FINE_UP    = 4'h1;
    localparam logic [3:0] EXT_FINE_DN    = 4'h2;
    localparam logic [3:0] EXT_FINE_VOLUP = 4'hA;
    localparam logic [3:0] EXT_FINE_VOLDN = 4'hB;
    localparam logic [3:0] EXT_RETRIG     = 4'h9;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                range_warn;
    } note_result_t;

    typedef struct packed {
        logic [3:0] cmd;
        logic [7:0] param;
        logic       warn;
    } fx_result_t;

    function automatic logic [PERIOD_W-1:0] period_lookup(input logic [7:0] note);
        logic [PERIOD_W-1:0] p;
        case (note)
            8'd37: p = 12'd1712;  8'd38: p = 12'd1616;  8'd39: p = 12'd1524;
            8'd40: p = 12'd1440;  8'd41: p = 12'd1356;  8'd42: p = 12'd1280;
            8'd43: p = 12'd1208;  8'd44: p = 12'd1140;  8'd45: p = 12'd1076;
            8'd46: p = 12'd1016;  8'd47: p = 12'd960;   8'd48: p = 12'd906;
            8'd49: p = 12'd856;   8'd50: p = 12'd808;   8'd51: p = 12'd762;
            8'd52: p = 12'd720;   8'd53: p = 12'd678;   8'd54: p = 12'd640;
            8'd55: p = 12'd604;   8'd56: p = 12'd570;   8'd57: p = 12'd538;
            8'd58: p = 12'd508;   8'd59: p = 12'd480;   8'd60: p = 12'd453;
            8'd61: p = 12'd428;   8'd62: p = 12'd404;   8'd63: p = 12'd381;
            8'd64: p = 12'd360;   8'd65: p = 12'd339;   8'd66: p = 12'd320;
            8'd67: p = 12'd302;   8'd68: p = 12'd285;   8'd69: p = 12'd269;
            8'd70: p = 12'd254;   8'd71: p = 12'd240;   8'd72: p = 12'd226;
            8'd73: p = 12'd214;   8'd74: p = 12'd202;   8'd75: p = 12'd190;
            8'd76: p = 12'd180;   8'd77: p = 12'd170;   8'd78: p = 12'd160;
            8'd79: p = 12'd151;   8'd80: p = 12'd143;   8'd81: p = 12'd135;
            8'd82: p = 12'd127;   8'd83: p = 12'd120;   8'd84: p = 12'd113;
            8'd85: p = 12'd107;   8'd86: p = 12'd101;   8'd87: p = 12'd95;
            8'd88: p = 12'd90;    8'd89: p = 12'd85;    8'd90: p = 12'd80;
            8'd91: p = 12'd75;    8'd92: p = 12'd71;    8'd93: p = 12'd67;
            8'd94: p = 12'd63;    8'd95: p = 12'd60;    8'd96: p = 12'd56;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[rtl/core/mpce_period_rom.sv]
// note to amiga period lookup with range check
`default_nettype none

module mpce_period_rom (
    input  wire logic [7:0]            note_number,
    output mpce_pkg::note_result_t     note_res
);
    import mpce_pkg::*;

    logic [PERIOD_W-1:0] period;

    always_comb
    begin
        period              = period_lookup(note_number);
        note_res.period     = period;
        // table holes read zero, so they land below the minimum
        note_res.range_warn = (note_number != 8'd0)
                              && ((period < PERIOD_MIN) || (period > PERIOD_MAX));
    end

endmodule

`default_nettype wire

[rtl/core/mpce_fx_xlat.sv]
// effect and volume column translation to command nibble and parameter
`default_nettype none

module mpce_fx_xlat (
    input  wire logic [4:0]          effect_kind,
    input  wire logic [7:0]          effect_param,
    input  wire logic [1:0]          volume_column_kind,
    input  wire logic [7:0]          volume_column_param,
    output mpce_pkg::fx_result_t     fx_res
);
    import mpce_pkg::*;

    logic [15:0] div_prod;
    logic [4:0]  tens;
    logic [7:0]  ones_full;
    logic [7:0]  bcd;
    logic [3:0]  hi;
    logic [3:0]  lo;

    // divide by ten through reciprocal multiply, exact for all byte values
    always_comb
    begin
        div_prod  = {8'd0, effect_param} * 16'd205;
        tens      = div_prod[15:11];
        ones_full = effect_param - {tens, 3'b000} - {2'b00, tens, 1'b0};
        bcd       = {tens[3:0], ones_full[3:0]};
    end

    assign hi = effect_param[7:4];
    assign lo = effect_param[3:0];

    always_comb
    begin
        fx_res.cmd   = CMD_NONE;
        fx_res.param = effect_param;
        fx_res.warn  = 1'b0;
        case (vol_kind_t'(volume_column_kind))
            VOL_SET:
            begin
                fx_res.cmd   = CMD_VOLUME;
                fx_res.param = volume_column_param;
            end
            VOL_NONE:
            begin
                case (effect_kind_t'(effect_kind))
                    KIND_NONE:     fx_res.param = 8'h00;
                    KIND_ARPEGGIO: fx_res.cmd = CMD_NONE;
                    KIND_PORTA_UP, KIND_PORTA_DOWN:
                    begin
                        fx_res.cmd = (effect_kind_t'(effect_kind) == KIND_PORTA_UP)
                                     ? CMD_PORTA_UP : CMD_PORTA_DN;
                        if (hi == 4'hE || hi == 4'hF)
                        begin
                            fx_res.cmd   = CMD_EXTENDED;
                            fx_res.param[7:4] = (effect_kind_t'(effect_kind) == KIND_PORTA_UP)
                                                ? EXT_FINE_UP : EXT_FINE_DN;
                            // extra-fine steps are quartered
                            fx_res.param[3:0] = (hi == 4'hE) ? {2'b00, lo[3:2]} : lo;
                        end
                    end
                    KIND_TONEPORTA: fx_res.cmd = CMD_TONEPORTA;
                    KIND_VIBRATO:   fx_res.cmd = CMD_VIBRATO;
                    KIND_TONEP_VOL: fx_res.cmd = CMD_TONEP_VOL;
                    KIND_VIBRA_VOL: fx_res.cmd = CMD_VIBRA_VOL;
                    KIND_TREMOLO:   fx_res.cmd = CMD_TREMOLO;
                    KIND_PANNING:   fx_res.cmd = CMD_PANNING;
                    KIND_OFFSET:    fx_res.cmd = CMD_OFFSET;
                    KIND_VOLSLIDE:
                    begin
                        fx_res.cmd = CMD_VOLSLIDE;
                        if (hi != 4'h0 && lo != 4'h0)
                        begin
                            if (hi == 4'hF)
                            begin
                                fx_res.cmd   = CMD_EXTENDED;
                                fx_res.param = {EXT_FINE_VOLDN, lo};
                            end
                            else if (lo == 4'hF)
                            begin
                                fx_res.cmd   = CMD_EXTENDED;
                                fx_res.param = {EXT_FINE_VOLUP, hi};
                            end
                        end
                    end
                    KIND_JUMP:   fx_res.cmd = CMD_JUMP;
                    KIND_VOLUME: fx_res.cmd = CMD_VOLUME;
                    KIND_BREAK:
                    begin
                        fx_res.cmd   = CMD_BREAK;
                        fx_res.param = bcd;
                    end
                    KIND_SPEED:  fx_res.cmd = CMD_SPEED;
                    KIND_TEMPO:  fx_res.cmd = CMD_SPEED;
                    KIND_SPECIAL:
                    begin
                        fx_res.cmd = CMD_EXTENDED;
                        // renumber the extended sub-commands that moved
                        case (hi)
                            4'h1:    fx_res.param = {4'h3, lo};
                            4'h2:    fx_res.param = {4'h5, lo};
                            4'h3:    fx_res.param = {4'h4, lo};
                            4'h4:    fx_res.param = {4'h7, lo};
                            4'hB:    fx_res.param = {4'h6, lo};
                            default: fx_res.param = effect_param;
                        endcase
                    end
                    KIND_RETRIG:
                    begin
                        fx_res.cmd   = CMD_EXTENDED;
                        fx_res.param = {EXT_RETRIG, lo};
                    end
                    default: fx_res.warn = 1'b1;
                endcase
            end
            default: fx_res.warn = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/mod_pattern_cell_encoder.sv]
// top level: tracker cell to four-byte mod pattern cell, two register stages
// a request taken into the input registers moves on to the result registers,
// where done rises with its result; one request per cycle, busy is low
// the period table and the effect translation sit between the input and
// result registers
// reset clears the stage valid flags only; the receiver cannot stall
`default_nettype none

module mod_pattern_cell_encoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [7:0] note_number,
    input  wire logic [7:0] instrument_number,
    input  wire logic [4:0] effect_kind,
    input  wire logic [7:0] effect_param,
    input  wire logic [1:0] volume_column_kind,
    input  wire logic [7:0] volume_column_param,
    output logic            done,
    output logic [7:0]      cell_byte0,
    output logic [7:0]      cell_byte1,
    output logic [7:0]      cell_byte2,
    output logic [7:0]      cell_byte3,
    output logic            note_range_warning,
    output logic            effect_warning
);
    import mpce_pkg::*;

    logic       valid_reg;
    logic [7:0] note_reg;
    logic [4:0] inst_reg;
    logic [4:0] kind_reg;
    logic [7:0] param_reg;
    logic [1:0] vkind_reg;
    logic [7:0] vparam_reg;

    logic       done_reg;
    logic [7:0] byte0_reg, byte0_next;
    logic [7:0] byte1_reg, byte1_next;
    logic [7:0] byte2_reg, byte2_next;
    logic [7:0] byte3_reg, byte3_next;
    logic       nwarn_reg;
    logic       fwarn_reg;

    note_result_t note_res;
    fx_result_t   fx_res;

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            note_reg   <= note_number;
            inst_reg   <= instrument_number[4:0];
            kind_reg   <= effect_kind;
            param_reg  <= effect_param;
            vkind_reg  <= volume_column_kind;
            vparam_reg <= volume_column_param;
        end
    end

    mpce_period_rom u_rom (
        .note_number (note_reg),
        .note_res    (note_res)
    );

    mpce_fx_xlat u_xlat (
        .effect_kind         (kind_reg),
        .effect_param        (param_reg),
        .volume_column_kind  (vkind_reg),
        .volume_column_param (vparam_reg),
        .fx_res              (fx_res)
    );

    always_comb
    begin
        byte0_next = {3'b000, inst_reg[4], note_res.period[11:8]};
        byte1_next = note_res.period[7:0];
        byte2_next = {inst_reg[3:0], fx_res.cmd};
        byte3_next = fx_res.param;
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            byte0_reg <= byte0_next;
            byte1_reg <= byte1_next;
            byte2_reg <= byte2_next;
            byte3_reg <= byte3_next;
            nwarn_reg <= note_res.range_warn;
            fwarn_reg <= fx_res.warn;
        end
    end

    assign done               = done_reg;
    assign cell_byte0         = byte0_reg;
    assign cell_byte1         = byte1_reg;
    assign cell_byte2         = byte2_reg;
    assign cell_byte3         = byte3_reg;
    assign note_range_warning = nwarn_reg;
    assign effect_warning     = fwarn_reg;

    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("request did not produce a result two cycles later");

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result strobe without a matching request");

    a_set_volume_wins: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && volume_column_kind == VOL_SET) |-> ##2
        (cell_byte2[3:0] == CMD_VOLUME && cell_byte3 == $past(volume_column_param, 2)
         && !effect_warning))
        else $error("set volume not encoded as volume command");

    a_warn_no_command: assert property (@(posedge clk) disable iff (!rst_n)
        (done && effect_warning) |-> (cell_byte2[3:0] == CMD_NONE))
        else $error("unsupported effect carries a command");

endmodule

`default_nettype wire
